[rtl/assert_macros.svh]
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[rtl/mkdb_pkg.sv]
package mkdb_pkg;

    // bus and stream widths
    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int CHAR_W     = 7;
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 2;

    // key queue sizing
    localparam int KEY_QUEUE_DEPTH = 16;
    localparam int KQ_IDX_W = (KEY_QUEUE_DEPTH > 1) ? $clog2(KEY_QUEUE_DEPTH) : 1;
    localparam int KQ_CNT_W = $clog2(KEY_QUEUE_DEPTH + 1);
    localparam int KQ_SUM_W = KQ_IDX_W + 1;
    localparam logic [KQ_CNT_W-1:0] KQ_FULL = KQ_CNT_W'(KEY_QUEUE_DEPTH);
    localparam logic [KQ_IDX_W-1:0] KQ_LAST = KQ_IDX_W'(KEY_QUEUE_DEPTH - 1);
    localparam logic [KQ_SUM_W-1:0] KQ_WRAP = KQ_SUM_W'(KEY_QUEUE_DEPTH);

    // address map
    localparam logic [7:0]        MIRROR_PAGE    = 8'hD0;
    localparam logic [ADDR_W-1:0] MIRROR_MASK    = 16'hFF13;
    localparam logic [ADDR_W-1:0] KEY_REG        = 16'hD010;
    localparam logic [ADDR_W-1:0] KEY_STATUS_REG = 16'hD011;
    localparam logic [ADDR_W-1:0] DISPLAY_REG    = 16'hD012;
    localparam logic [ADDR_W-1:0] MONITOR_BASE   = 16'hFF00;
    localparam logic [ADDR_W-1:0] ADDR_LAST      = 16'hFFFF;

    // byte constants
    localparam logic [BYTE_W-1:0] KEY_FLAG   = 8'h80;
    localparam logic [BYTE_W-1:0] KEY_READY  = 8'h80;
    localparam logic [BYTE_W-1:0] KEY_NONE   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_MASK  = 8'h7F;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 7'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 7'h0A;

    typedef enum logic [1:0] {
        ACT_KEY   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2
    } mkdb_action_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS
    } mkdb_state_t;

    // controller to datapath
    typedef struct packed {
        logic              clr_we;
        logic [ADDR_W-1:0] clr_addr;
        logic              accept;
        logic              load_out;
    } mkdb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } mkdb_sts_t;

    // monitor rom image placed at FF00
    localparam logic [BYTE_W-1:0] MONITOR_IMAGE [256] = '{
        8'hd8, 8'h58, 8'ha0, 8'h7f, 8'h8c, 8'h12, 8'hd0, 8'ha9, 8'ha7, 8'h8d, 8'h11, 8'hd0,
        8'h8d, 8'h13, 8'hd0, 8'hc9, 8'hdf, 8'hf0, 8'h13, 8'hc9, 8'h9b, 8'hf0, 8'h03, 8'hc8,
        8'h10, 8'h0f, 8'ha9, 8'hdc, 8'h20, 8'hef, 8'hff, 8'ha9, 8'h8d, 8'h20, 8'hef, 8'hff,
        8'ha0, 8'h01, 8'h88, 8'h30, 8'hf6, 8'had, 8'h11, 8'hd0, 8'h10, 8'hfb, 8'had, 8'h10,
        8'hd0, 8'h99, 8'h00, 8'h02, 8'h20, 8'hef, 8'hff, 8'hc9, 8'h8d, 8'hd0, 8'hd4, 8'ha0,
        8'hff, 8'ha9, 8'h00, 8'haa, 8'h0a, 8'h85, 8'h2b, 8'hc8, 8'hb9, 8'h00, 8'h02, 8'hc9,
        8'h8d, 8'hf0, 8'hd4, 8'hc9, 8'hae, 8'h90, 8'hf4, 8'hf0, 8'hf0, 8'hc9, 8'hba, 8'hf0,
        8'heb, 8'hc9, 8'hd2, 8'hf0, 8'h3b, 8'h86, 8'h28, 8'h86, 8'h29, 8'h84, 8'h2a, 8'hb9,
        8'h00, 8'h02, 8'h49, 8'hb0, 8'hc9, 8'h0a, 8'h90, 8'h06, 8'h69, 8'h88, 8'hc9, 8'hfa,
        8'h90, 8'h11, 8'h0a, 8'h0a, 8'h0a, 8'h0a, 8'ha2, 8'h04, 8'h0a, 8'h26, 8'h28, 8'h26,
        8'h29, 8'hca, 8'hd0, 8'hf8, 8'hc8, 8'hd0, 8'he0, 8'hc4, 8'h2a, 8'hf0, 8'h97, 8'h24,
        8'h2b, 8'h50, 8'h10, 8'ha5, 8'h28, 8'h81, 8'h26, 8'he6, 8'h26, 8'hd0, 8'hb5, 8'he6,
        8'h27, 8'h4c, 8'h44, 8'hff, 8'h6c, 8'h24, 8'h00, 8'h30, 8'h2b, 8'ha2, 8'h02, 8'hb5,
        8'h27, 8'h95, 8'h25, 8'h95, 8'h23, 8'hca, 8'hd0, 8'hf7, 8'hd0, 8'h14, 8'ha9, 8'h8d,
        8'h20, 8'hef, 8'hff, 8'ha5, 8'h25, 8'h20, 8'hdc, 8'hff, 8'ha5, 8'h24, 8'h20, 8'hdc,
        8'hff, 8'ha9, 8'hba, 8'h20, 8'hef, 8'hff, 8'ha9, 8'ha0, 8'h20, 8'hef, 8'hff, 8'ha1,
        8'h24, 8'h20, 8'hdc, 8'hff, 8'h86, 8'h2b, 8'ha5, 8'h24, 8'hc5, 8'h28, 8'ha5, 8'h25,
        8'he5, 8'h29, 8'hb0, 8'hc1, 8'he6, 8'h24, 8'hd0, 8'h02, 8'he6, 8'h25, 8'ha5, 8'h24,
        8'h29, 8'h07, 8'h10, 8'hc8, 8'h48, 8'h4a, 8'h4a, 8'h4a, 8'h4a, 8'h20, 8'he5, 8'hff,
        8'h68, 8'h29, 8'h0f, 8'h09, 8'hb0, 8'hc9, 8'hba, 8'h90, 8'h02, 8'h69, 8'h06, 8'h2c,
        8'h12, 8'hd0, 8'h30, 8'hfb, 8'h8d, 8'h12, 8'hd0, 8'h60, 8'h00, 8'h00, 8'h00, 8'h0f,
        8'h00, 8'hff, 8'h00, 8'h00
    };

    // upper-case a..z, leave everything else
    function automatic logic [BYTE_W-1:0] to_upper(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

[rtl/mkdb_ctrl.sv]
module mkdb_ctrl
    import mkdb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  mkdb_sts_t sts,
    output mkdb_cmd_t cmd
);

    mkdb_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    // state and clear counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.clr_addr = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we   = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/mkdb_datapath.sv]
`include "assert_macros.svh"

module mkdb_datapath
    import mkdb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mkdb_cmd_t            cmd,
    output mkdb_sts_t            sts,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    // byte store and key queue
    logic [BYTE_W-1:0] mem [0:(1 << ADDR_W) - 1];
    logic [BYTE_W-1:0] key_queue [KEY_QUEUE_DEPTH];

    logic [KQ_IDX_W-1:0] head_reg, head_next;
    logic [KQ_CNT_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0]   key_reg, key_next;
    logic [BYTE_W-1:0]   stat_reg, stat_next;
    logic [BYTE_W-1:0]   disp_reg, disp_next;

    // pending result of the item at work
    logic [BYTE_W-1:0] pend_rd_reg, pend_rd_next;
    logic              pend_mem_reg, pend_mem_next;
    logic              pend_dv_reg, pend_dv_next;
    logic [CHAR_W-1:0] pend_dch_reg, pend_dch_next;
    logic              pend_drop_reg, pend_drop_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_rd_reg;
    logic              m_dv_reg;
    logic [CHAR_W-1:0] m_dch_reg;
    logic              m_drop_reg;

    logic [BYTE_W-1:0] mem_rd_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_wa;
    logic [BYTE_W-1:0] mem_wd;

    logic [ADDR_W-1:0]   in_addr, addr_dec;
    logic [BYTE_W-1:0]   in_data, disp_char;
    mkdb_action_t        in_act;
    logic                is_special;
    logic [KQ_SUM_W-1:0] tail_sum;
    logic [KQ_IDX_W-1:0] tail;
    logic                q_we;

    assign in_addr = s_tdata[ADDR_W-1:0];
    assign in_data = s_tdata[ADDR_W +: BYTE_W];
    assign in_act  = mkdb_action_t'(s_tuser);

    // page D0 mirror decode
    assign addr_dec = (in_addr[ADDR_W-1:8] == MIRROR_PAGE) ? (in_addr & MIRROR_MASK) : in_addr;
    assign is_special = (addr_dec == KEY_REG) || (addr_dec == KEY_STATUS_REG)
                     || (addr_dec == DISPLAY_REG);

    // queue tail, wraps at the depth
    assign tail_sum = {1'b0, head_reg} + KQ_SUM_W'(count_reg);
    assign tail     = (tail_sum >= KQ_WRAP) ? KQ_IDX_W'(tail_sum - KQ_WRAP)
                                            : KQ_IDX_W'(tail_sum);

    assign disp_char = to_upper(in_data & CHAR_MASK);

    // item execution
    always_comb begin
        head_next      = head_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        stat_next      = stat_reg;
        disp_next      = disp_reg;
        pend_rd_next   = pend_rd_reg;
        pend_mem_next  = pend_mem_reg;
        pend_dv_next   = pend_dv_reg;
        pend_dch_next  = pend_dch_reg;
        pend_drop_next = pend_drop_reg;
        q_we           = 1'b0;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        if (cmd.accept) begin
            pend_rd_next   = '0;
            pend_mem_next  = 1'b0;
            pend_dv_next   = 1'b0;
            pend_dch_next  = '0;
            pend_drop_next = 1'b0;
            case (in_act)
                ACT_KEY: begin
                    if (count_reg >= KQ_FULL) begin
                        pend_drop_next = 1'b1;
                    end else begin
                        q_we       = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_READ: begin
                    if (addr_dec == KEY_REG) begin
                        pend_rd_next = key_reg;
                        if (count_reg != '0) begin
                            key_next     = key_queue[head_reg];
                            pend_rd_next = key_queue[head_reg];
                            head_next    = (head_reg == KQ_LAST) ? '0 : head_reg + 1'b1;
                            count_next   = count_reg - 1'b1;
                        end
                    end else if (addr_dec == KEY_STATUS_REG) begin
                        stat_next    = (count_reg != '0) ? KEY_READY : KEY_NONE;
                        pend_rd_next = stat_next;
                    end else if (addr_dec == DISPLAY_REG) begin
                        pend_rd_next = disp_reg;
                    end else begin
                        mem_re        = 1'b1;
                        pend_mem_next = 1'b1;
                    end
                end
                ACT_WRITE: begin
                    if (addr_dec == DISPLAY_REG) begin
                        disp_next     = disp_char;
                        pend_dv_next  = 1'b1;
                        pend_dch_next = (disp_char[CHAR_W-1:0] == CHAR_CR) ? CHAR_LF
                                                                           : disp_char[CHAR_W-1:0];
                    end else if (!is_special) begin
                        mem_we = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        // clearing pass owns the write port
        if (cmd.clr_we) begin
            mem_we = 1'b1;
        end
    end

    // memory write source
    always_comb begin
        mem_wa = addr_dec;
        mem_wd = in_data;
        if (cmd.clr_we) begin
            mem_wa = cmd.clr_addr;
            mem_wd = (cmd.clr_addr[ADDR_W-1:8] == MONITOR_BASE[ADDR_W-1:8])
                   ? MONITOR_IMAGE[cmd.clr_addr[7:0]] : '0;
        end
    end

    // byte store, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            mem_rd_reg <= mem[addr_dec];
        end
    end

    // key queue entries
    always_ff @(posedge aclk) begin
        if (q_we) begin
            key_queue[tail] <= to_upper(in_data) | KEY_FLAG;
        end
    end

    // output handshake
    assign sts.out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            key_reg     <= '0;
            stat_reg    <= '0;
            disp_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            key_reg     <= key_next;
            stat_reg    <= stat_next;
            disp_reg    <= disp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_rd_reg   <= pend_rd_next;
        pend_mem_reg  <= pend_mem_next;
        pend_dv_reg   <= pend_dv_next;
        pend_dch_reg  <= pend_dch_next;
        pend_drop_reg <= pend_drop_next;
        if (cmd.load_out) begin
            m_rd_reg   <= pend_mem_reg ? mem_rd_reg : pend_rd_reg;
            m_dv_reg   <= pend_dv_reg;
            m_dch_reg  <= pend_dch_reg;
            m_drop_reg <= pend_drop_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_dch_reg, m_rd_reg};
    assign m_tuser  = {m_drop_reg, m_dv_reg};

    `ASSERT_CLK(a_count_bound, aclk, aresetn, count_reg <= KQ_FULL, "key count above depth")
    `ASSERT_CLK(a_no_overwrite, aclk, aresetn, cmd.load_out |-> (!m_valid_reg || m_tready), "result overwritten")
    `ASSERT_CLK(a_display_no_read, aclk, aresetn, (m_valid_reg && m_dv_reg) |-> (m_rd_reg == '0), "display item carries read data")
    `ASSERT_CLK(a_no_item_in_clear, aclk, aresetn, cmd.clr_we |-> !cmd.accept, "item accepted during clearing pass")

endmodule

[rtl/mirrored_keyboard_display_bus.sv]
// channel  | ports         | tdata (low bit up)                  | tuser (low bit up)
// input    | s_t*          | address[15:0], data_in[23:16]       | action[1:0]
// result   | m_t*          | read_data[7:0], display_char[14:8]  | display_valid[0], key_dropped[1]
//
// an item is accepted, then the registered byte-store read port delivers
// its data and the result is loaded into the output register
// a result waiting on m_tready holds the block in its access state
// after reset a clearing pass writes all 65536 store bytes (zeros and the
// monitor image at FF00), one per cycle, before the first item is accepted
// reset is synchronous, active low on aresetn
module mirrored_keyboard_display_bus
    import mkdb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // address, data_in
    input  logic [S_TUSER_W-1:0] s_tuser,  // action
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // read_data, display_char, zero pad
    output logic [M_TUSER_W-1:0] m_tuser   // display_valid, key_dropped
);

    mkdb_cmd_t cmd;
    mkdb_sts_t sts;

    // sequencer
    mkdb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // store, queue and output register
    mkdb_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[bench/bus_access_checker.sv]
module bus_access_checker
    import mkdb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // address, data_in
    input  logic [S_TUSER_W-1:0] s_tuser,  // action
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,  // read_data, display_char, zero pad
    input  logic [M_TUSER_W-1:0] m_tuser,  // display_valid, key_dropped
    output int                   mismatches,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 16;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              display_valid;
        logic [CHAR_W-1:0] display_char;
        logic              key_dropped;
    } bus_result_t;

    // shadow copy of the store and the key fifo
    logic [BYTE_W-1:0] mem_model [0:65535];
    logic [BYTE_W-1:0] key_fifo [0:KEY_QUEUE_DEPTH-1];
    int unsigned       keys_waiting;
    int unsigned       fifo_head;

    // predicted results not yet seen on the result side
    bus_result_t       want_ring [0:RING_DEPTH-1];
    int                ring_wr;
    int                ring_rd;
    int                ring_fill;

    // a..z become A..Z, anything else passes
    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return {c[7:6], 1'b0, c[4:0]};
        end
        return c;
    endfunction

    // page D0 aliases onto D000-D003 and D010-D013; the io registers sit at D010-D012
    function automatic logic [ADDR_W-1:0] map_address(input logic [ADDR_W-1:0] a);
        if (a[15:8] == MIRROR_PAGE) begin
            return a & MIRROR_MASK;
        end
        return a;
    endfunction

    function automatic string show(input bus_result_t r);
        return $sformatf("rd=%02h dv=%0d ch=%02h drop=%0d",
                         r.read_data, r.display_valid, r.display_char, r.key_dropped);
    endfunction

    task automatic clear_model();
        for (int i = 0; i < 65536; i++) begin
            mem_model[i] = (i >= int'(MONITOR_BASE)) ? MONITOR_IMAGE[i - int'(MONITOR_BASE)]
                                                     : 8'h00;
        end
        for (int i = 0; i < KEY_QUEUE_DEPTH; i++) begin
            key_fifo[i] = 8'h00;
        end
        keys_waiting = 0;
        fifo_head    = 0;
        ring_wr      = 0;
        ring_rd      = 0;
        ring_fill    = 0;
    endtask

    // apply one access to the shadow state and return what the bus answers
    function automatic bus_result_t predict_access(input logic [1:0] act,
                                                   input logic [ADDR_W-1:0] raw_addr,
                                                   input logic [BYTE_W-1:0] din);
        bus_result_t       r;
        logic [ADDR_W-1:0] a;
        logic [BYTE_W-1:0] ch;
        r = '0;
        a = map_address(raw_addr);
        case (mkdb_action_t'(act))
            ACT_KEY: begin
                if (keys_waiting >= KEY_QUEUE_DEPTH) begin
                    r.key_dropped = 1'b1;
                end else begin
                    key_fifo[(fifo_head + keys_waiting) % KEY_QUEUE_DEPTH] =
                        fold_case(din) | KEY_FLAG;
                    keys_waiting++;
                end
            end
            ACT_READ: begin
                if (a == KEY_REG) begin
                    if (keys_waiting != 0) begin
                        mem_model[KEY_REG] = key_fifo[fifo_head];
                        fifo_head = (fifo_head + 1) % KEY_QUEUE_DEPTH;
                        keys_waiting--;
                    end
                end else if (a == KEY_STATUS_REG) begin
                    mem_model[KEY_STATUS_REG] = (keys_waiting != 0) ? KEY_READY : KEY_NONE;
                end
                r.read_data = mem_model[a];
            end
            ACT_WRITE: begin
                if (a == DISPLAY_REG) begin
                    ch = fold_case(din & CHAR_MASK);
                    mem_model[DISPLAY_REG] = ch;
                    r.display_valid = 1'b1;
                    r.display_char  = (ch[CHAR_W-1:0] == CHAR_CR) ? CHAR_LF : ch[CHAR_W-1:0];
                end else if (a != KEY_REG && a != KEY_STATUS_REG) begin
                    mem_model[a] = din;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // append one predicted result to the ring
    task automatic ring_put(input bus_result_t r);
        if (ring_fill >= RING_DEPTH) begin
            flag_mismatch("too many items in flight");
        end else begin
            want_ring[ring_wr] = r;
            ring_wr = (ring_wr + 1) % RING_DEPTH;
            ring_fill++;
        end
    endtask

    // predict on accepted inputs, compare on accepted results
    always @(posedge aclk) begin
        bus_result_t want;
        bus_result_t got;
        if (!aresetn) begin
            clear_model();
            mismatches = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                ring_put(predict_access(s_tuser, s_tdata[15:0], s_tdata[23:16]));
            end
            if (m_tvalid && m_tready) begin
                got.read_data     = m_tdata[7:0];
                got.display_char  = m_tdata[14:8];
                got.display_valid = m_tuser[0];
                got.key_dropped   = m_tuser[1];
                if (ring_fill == 0) begin
                    flag_mismatch({"result with nothing pending: ", show(got)});
                end else begin
                    want = want_ring[ring_rd];
                    ring_rd = (ring_rd + 1) % RING_DEPTH;
                    ring_fill--;
                    if (got !== want) begin
                        flag_mismatch({"expected ", show(want), " got ", show(got)});
                    end
                end
            end
        end
        outstanding <= ring_fill;
    end

endmodule

[bench/testbench.sv]
module testbench;
    import mkdb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CALM_ITEMS   = 150;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // address, data_in
    logic [S_TUSER_W-1:0] s_tuser;   // action
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // read_data, display_char, zero pad
    logic [M_TUSER_W-1:0] m_tuser;   // display_valid, key_dropped
    int                   mismatches;
    int                   outstanding;

    int                items_sent;
    bit                calm;
    bit                send_gaps;
    logic [ADDR_W-1:0] hot_addr [8];

    mirrored_keyboard_display_bus dut (.*);

    bus_access_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side back-pressure in random bursts
    initial begin
        bit stall_mode;
        stall_mode = 1'b1;
        m_tready <= 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 199) == 0) begin
                stall_mode = !stall_mode;
            end
            if (!calm && stall_mode && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // present one item and hold it until accepted
    task automatic issue(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
                         input logic [BYTE_W-1:0] din);
        if (items_sent % 120 == 0) begin
            send_gaps = ($urandom_range(0, 2) != 0);
        end
        if (!calm && send_gaps && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {din, addr};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        calm = (items_sent >= RANDOM_ITEMS - CALM_ITEMS);
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        case ($urandom_range(0, 5))
            0: return ADDR_W'($urandom);
            1: return {MIRROR_PAGE, 8'($urandom)};
            2: return MONITOR_BASE | ADDR_W'($urandom_range(0, 255));
            3: return hot_addr[$urandom_range(0, 7)];
            4: begin
                case ($urandom_range(0, 2))
                    0: return KEY_REG;
                    1: return KEY_STATUS_REG;
                    default: return DISPLAY_REG;
                endcase
            end
            default: return ADDR_W'($urandom_range(0, 511));
        endcase
    endfunction

    // the exact register or one of its aliases in page D0
    function automatic logic [ADDR_W-1:0] alias_of(input logic [ADDR_W-1:0] a);
        if (a[15:8] != MIRROR_PAGE || $urandom_range(0, 1) == 0) begin
            return a;
        end
        return {MIRROR_PAGE, a[7:0] | (8'($urandom) & ~MIRROR_MASK[7:0])};
    endfunction

    function automatic logic [BYTE_W-1:0] key_code();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(8'h61, 8'h7A));
            1: return 8'($urandom_range(8'h41, 8'h5A));
            2: return 8'h0D;
            default: return 8'($urandom);
        endcase
    endfunction

    // stimulus and verdict
    initial begin
        logic [ADDR_W-1:0] a;
        int                n;
        items_sent = 0;
        calm       = 1'b0;
        send_gaps  = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: store extremes, empty queue, key folding, aliases, display
        issue(ACT_READ, MONITOR_BASE, 8'h00);
        issue(ACT_READ, ADDR_LAST, 8'h00);
        issue(ACT_READ, 16'h0000, 8'h00);
        issue(ACT_WRITE, 16'h0000, 8'hFF);
        issue(ACT_READ, 16'h0000, 8'h00);
        issue(ACT_WRITE, ADDR_LAST, 8'hA5);
        issue(ACT_READ, ADDR_LAST, 8'h00);
        issue(ACT_READ, KEY_STATUS_REG, 8'h00);
        issue(ACT_READ, KEY_REG, 8'h00);
        issue(ACT_KEY, 16'hFFFF, 8'h61);
        issue(ACT_KEY, 16'h0000, 8'h00);
        issue(ACT_KEY, 16'h1234, 8'hFF);
        issue(ACT_KEY, 16'h0000, 8'h7A);
        issue(ACT_READ, 16'hD0F1, 8'h00);
        issue(ACT_READ, KEY_REG, 8'h00);
        issue(ACT_READ, 16'hD0FC, 8'h00);
        issue(ACT_WRITE, KEY_REG, 8'h55);
        issue(ACT_WRITE, KEY_STATUS_REG, 8'h55);
        issue(ACT_READ, KEY_REG, 8'h00);
        issue(ACT_WRITE, DISPLAY_REG, 8'hE1);
        issue(ACT_WRITE, DISPLAY_REG, 8'h8D);
        issue(ACT_READ, DISPLAY_REG, 8'h00);
        issue(ACT_WRITE, 16'hD0F2, 8'h7F);
        issue(ACT_UNUSED, KEY_REG, 8'hFF);
        issue(ACT_READ, 16'hD013, 8'h00);

        foreach (hot_addr[i]) begin
            hot_addr[i] = (i < 2) ? {MIRROR_PAGE, 8'($urandom)} : ADDR_W'($urandom);
        end
        items_sent = 0;

        // random: mostly structured sequences with random content
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    // typing burst, often past the queue depth
                    n = $urandom_range(1, 20);
                    repeat (n) issue(ACT_KEY, ADDR_W'($urandom), key_code());
                end
                2, 3: begin
                    // polling and draining the keys
                    n = $urandom_range(1, 20);
                    repeat (n) begin
                        if ($urandom_range(0, 2) == 0) begin
                            issue(ACT_READ, alias_of(KEY_STATUS_REG), 8'($urandom));
                        end else begin
                            issue(ACT_READ, alias_of(KEY_REG), 8'($urandom));
                        end
                    end
                end
                4, 5, 6: begin
                    // write then read back, possibly through an alias
                    a = pick_address();
                    issue(ACT_WRITE, a, 8'($urandom));
                    if ($urandom_range(0, 1) == 0) begin
                        issue(mkdb_action_t'($urandom_range(0, 2)), pick_address(),
                              8'($urandom));
                    end
                    issue(ACT_READ, alias_of(a), 8'($urandom));
                end
                7: begin
                    // characters to the display
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        case ($urandom_range(0, 3))
                            0: issue(ACT_WRITE, alias_of(DISPLAY_REG),
                                     ($urandom_range(0, 1) != 0) ? 8'h8D : 8'h0D);
                            1: issue(ACT_WRITE, alias_of(DISPLAY_REG),
                                     8'($urandom_range(8'h61, 8'h7A)) | 8'($urandom_range(0, 1) << 7));
                            default: issue(ACT_WRITE, alias_of(DISPLAY_REG), 8'($urandom));
                        endcase
                    end
                    issue(ACT_READ, alias_of(DISPLAY_REG), 8'($urandom));
                end
                default: begin
                    // noise
                    issue(mkdb_action_t'($urandom_range(0, 2)), ADDR_W'($urandom),
                          8'($urandom));
                end
            endcase
        end
        s_tvalid <= 1'b0;

        // drain what is still in flight
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
